// ===== hw/rtl/u8ut_pkg.sv =====
package u8ut_pkg;

   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] UPPER_A      = 8'h41;
   localparam logic [7:0] UPPER_Z      = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [7:0] LEAD_C2      = 8'hC2;
   localparam logic [7:0] LEAD_C3      = 8'hC3;
   localparam logic [7:0] LEAD_DF      = 8'hDF;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_E1      = 8'hE1;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_EF      = 8'hEF;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] CONT_BA      = 8'hBA;
   localparam logic [7:0] CONT_9E      = 8'h9E;
   localparam logic [7:0] CONT_9F      = 8'h9F;
   localparam logic [7:0] CHAR_QMARK   = 8'h3F;
   localparam logic [7:0] CHAR_A       = 8'h61;
   localparam logic [7:0] CHAR_E       = 8'h65;
   localparam logic [7:0] CHAR_O       = 8'h6F;
   localparam logic [7:0] CHAR_S       = 8'h73;
   localparam logic [7:0] CHAR_U       = 8'h75;
   localparam logic [15:0] SIZE_RESET  = 16'd256;

   typedef enum logic [1:0] {
      HALT_NONE  = 2'd0,
      HALT_TRUNC = 2'd1,
      HALT_ENC   = 2'd2
   } halt_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_C3   = 3'd1,
      PH_E1   = 3'd2,
      PH_E1BA = 3'd3,
      PH_GEN  = 3'd4,
      PH_LOW  = 3'd5,
      PH_HIGH = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] c1;
      logic [7:0] c2;
      logic       two;
      logic       is_end;
      logic [1:0] status;
   } entry_type;

endpackage

// ===== hw/rtl/u8ut_front.sv =====
module u8ut_front
   import u8ut_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  in_byte,
   input  logic        csr_write,
   input  logic [15:0] csr_data,
   output logic        emit,
   output entry_type   entry
);

   logic [15:0] out_size_ff, out_size_in;
   logic [15:0] space_ff, space_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  pending_ff, pending_in;
   halt_type    halt_ff, halt_in;

   logic [15:0] reload_space;
   logic        ok;
   logic        pair;
   logic [7:0]  p1, p2;
   logic [1:0]  pending_dec;

   assign reload_space = (out_size_ff == 16'd0) ? 16'd0 : out_size_ff - 16'd1;
   assign pending_dec  = pending_ff - 2'd1;

   always_comb begin
      case (phase_ff)
         PH_HIGH: ok = (pending_ff == 2'd2) ? (in_byte >= 8'hA0 && in_byte <= 8'hBF)
                                            : (in_byte >= 8'h90 && in_byte <= 8'hBF);
         PH_LOW:  ok = (pending_ff == 2'd2) ? (in_byte >= 8'h80 && in_byte <= 8'h9F)
                                            : (in_byte >= 8'h80 && in_byte <= 8'h8F);
         default: ok = (in_byte[7:6] == 2'b10);
      endcase
   end

   always_comb begin
      pair = 1'b0;
      p1   = CHAR_QMARK;
      p2   = CHAR_QMARK;
      if (phase_ff == PH_C3) begin
         case (in_byte)
            8'hA4, 8'h84: begin pair = 1'b1; p1 = CHAR_A; p2 = CHAR_E; end
            8'hB6, 8'h96: begin pair = 1'b1; p1 = CHAR_O; p2 = CHAR_E; end
            8'hBC, 8'h9C: begin pair = 1'b1; p1 = CHAR_U; p2 = CHAR_E; end
            CONT_9F:      begin pair = 1'b1; p1 = CHAR_S; p2 = CHAR_S; end
            default:      pair = 1'b0;
         endcase
      end else if (phase_ff == PH_E1BA && in_byte == CONT_9E) begin
         pair = 1'b1;
         p1   = CHAR_S;
         p2   = CHAR_S;
      end
   end

   always_comb begin
      out_size_in  = out_size_ff;
      space_in     = space_ff;
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      halt_in      = halt_ff;
      emit         = 1'b0;
      entry.c1     = CHAR_QMARK;
      entry.c2     = CHAR_QMARK;
      entry.two    = 1'b0;
      entry.is_end = 1'b0;
      entry.status = HALT_NONE;
      if (csr_write) begin
         out_size_in = csr_data;
         space_in    = (csr_data == 16'd0) ? 16'd0 : csr_data - 16'd1;
      end else if (accept) begin
         if (in_byte == 8'd0) begin
            emit         = 1'b1;
            entry.c1     = 8'd0;
            entry.c2     = 8'd0;
            entry.is_end = 1'b1;
            if (halt_ff != HALT_NONE) begin
               entry.status = halt_ff;
            end else if (phase_ff != PH_IDLE) begin
               entry.status = HALT_ENC;
            end
            space_in   = reload_space;
            phase_in   = PH_IDLE;
            pending_in = 2'd0;
            halt_in    = HALT_NONE;
         end else if (halt_ff != HALT_NONE) begin
            halt_in = halt_ff;
         end else if (phase_ff == PH_IDLE || phase_ff > PH_HIGH) begin
            phase_in = PH_IDLE;
            if (space_ff == 16'd0) begin
               halt_in = HALT_TRUNC;
            end else if (in_byte < ASCII_LIMIT) begin
               emit     = 1'b1;
               entry.c1 = (in_byte >= UPPER_A && in_byte <= UPPER_Z) ?
                          in_byte + CASE_OFFSET : in_byte;
               space_in = space_ff - 16'd1;
            end else if (in_byte >= LEAD_C2 && in_byte <= LEAD_DF) begin
               phase_in   = (in_byte == LEAD_C3) ? PH_C3 : PH_GEN;
               pending_in = 2'd1;
            end else if (in_byte >= LEAD_E0 && in_byte <= LEAD_EF) begin
               phase_in   = (in_byte == LEAD_E0) ? PH_HIGH :
                            (in_byte == LEAD_E1) ? PH_E1 :
                            (in_byte == LEAD_ED) ? PH_LOW : PH_GEN;
               pending_in = 2'd2;
            end else if (in_byte >= LEAD_F0 && in_byte <= LEAD_F4) begin
               phase_in   = (in_byte == LEAD_F0) ? PH_HIGH :
                            (in_byte == LEAD_F4) ? PH_LOW : PH_GEN;
               pending_in = 2'd3;
            end else begin
               halt_in    = HALT_ENC;
               pending_in = 2'd0;
            end
         end else if (!ok || pending_ff == 2'd0) begin
            halt_in    = HALT_ENC;
            phase_in   = PH_IDLE;
            pending_in = 2'd0;
         end else if (pending_dec != 2'd0) begin
            pending_in = pending_dec;
            phase_in   = (phase_ff == PH_E1 && in_byte == CONT_BA) ? PH_E1BA : PH_GEN;
         end else begin
            pending_in = 2'd0;
            phase_in   = PH_IDLE;
            emit       = 1'b1;
            if (pair && space_ff >= 16'd2) begin
               entry.c1  = p1;
               entry.c2  = p2;
               entry.two = 1'b1;
               space_in  = space_ff - 16'd2;
            end else if (space_ff != 16'd0) begin
               space_in = space_ff - 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_size_ff <= SIZE_RESET;
         space_ff    <= SIZE_RESET - 16'd1;
         phase_ff    <= PH_IDLE;
         pending_ff  <= 2'd0;
         halt_ff     <= HALT_NONE;
      end else begin
         out_size_ff <= out_size_in;
         space_ff    <= space_in;
         phase_ff    <= phase_in;
         pending_ff  <= pending_in;
         halt_ff     <= halt_in;
      end
   end

endmodule

// ===== hw/rtl/u8ut_fifo.sv =====
module u8ut_fifo
   import u8ut_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wdata,
   output logic      full,
   input  logic      pop,
   output entry_type rdata,
   output logic      empty
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   entry_type         mem_ff [DEPTH];
   logic [IW-1:0]     head_ff, head_in;
   logic [IW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + IW'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/u8ut_back.sv =====
module u8ut_back
   import u8ut_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  q_data,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_is_end,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   entry_type cur_ff, cur_in;
   logic      valid_ff, valid_in;
   logic      sec_ff, sec_in;
   logic      take, done;

   assign rsp_empty    = !valid_ff;
   assign rsp_out_char = sec_ff ? cur_ff.c2 : cur_ff.c1;
   assign rsp_is_end   = cur_ff.is_end;
   assign rsp_status   = cur_ff.status;
   assign rsp_last     = cur_ff.two ? sec_ff : 1'b1;

   assign take  = rsp_pop && valid_ff;
   assign done  = take && rsp_last;
   assign q_pop = (!valid_ff || done) && !q_empty;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      sec_in   = sec_ff;
      if (take && !rsp_last) begin
         sec_in = 1'b1;
      end else if (q_pop) begin
         cur_in   = q_data;
         valid_in = 1'b1;
         sec_in   = 1'b0;
      end else if (done) begin
         valid_in = 1'b0;
         sec_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sec_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sec_ff   <= sec_in;
      end
   end

endmodule

// ===== hw/rtl/utf8_umlaut_transliterator.sv =====
// A result is written to the entry queue when its byte is accepted, then loaded into the
// back end's single result register, which drains the queue and drives the rsp_ ports.
// Throughput: one input byte per cycle while the queue is not full; a two-letter form is
// popped one letter at a time. Input is held off while a csr write is offered.
// Reset: synchronous, active high; empties the queue, sets out_size to 256,
// reloads the space count and clears sequence and halt state.
module utf8_umlaut_transliterator
   import u8ut_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_end,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_out_size
);

   entry_type f_entry, q_data;
   logic      f_emit, q_full, q_empty, q_pop, accept;

   assign csr_ready = 1'b1;
   assign req_full  = q_full || csr_valid;
   assign accept    = req_push && !req_full;

   u8ut_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_out_size),
      .emit      (f_emit),
      .entry     (f_entry)
   );

   u8ut_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (f_emit),
      .wdata (f_entry),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_data),
      .empty (q_empty)
   );

   u8ut_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_data       (q_data),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_is_end   (rsp_is_end),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== bench/tb_utf8_umlaut_transliterator.sv =====
`timescale 1ns / 1ps

module tb_utf8_umlaut_transliterator;
   import u8ut_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASE_BYTES    = 90;

   localparam logic [7:0] END_BYTE      = 8'h00;
   localparam logic [7:0] CONT_MIN      = 8'h80;
   localparam logic [7:0] CONT_MAX      = 8'hBF;
   localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
   localparam logic [7:0] F0_SECOND_MIN = 8'h90;
   localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
   localparam logic [7:0] F4_SECOND_MAX = 8'h8F;
   localparam logic [7:0] TAIL_AE_LO    = 8'hA4;
   localparam logic [7:0] TAIL_AE_UP    = 8'h84;
   localparam logic [7:0] TAIL_OE_LO    = 8'hB6;
   localparam logic [7:0] TAIL_OE_UP    = 8'h96;
   localparam logic [7:0] TAIL_UE_LO    = 8'hBC;
   localparam logic [7:0] TAIL_UE_UP    = 8'h9C;
   localparam logic [7:0] UMLAUT_TAILS [7] = '{TAIL_AE_LO, TAIL_AE_UP, TAIL_OE_LO,
      TAIL_OE_UP, TAIL_UE_LO, TAIL_UE_UP, CONT_9F};
   localparam logic [15:0] SIZE_PLAN [8] = '{16'd1, 16'd2, 16'd3, 16'd65535,
      16'd0, 16'd5, SIZE_RESET, 16'd12};

   typedef struct {
      logic [7:0] ch;
      logic       is_end;
      halt_type   status;
      logic       last;
   } out_char_type;

   class char_stream_scoreboard;
      logic [15:0]  size_reg;
      logic [15:0]  room;
      phase_type    seq_phase;
      logic [1:0]   cont_left;
      halt_type     halt;
      out_char_type expected_chars[$];
      int           errors;
      int           chars_checked;
      int           ends_by_status[4];

      function new();
         size_reg = SIZE_RESET;
         restart();
      endfunction

      function void restart();
         room = (size_reg == 16'd0) ? 16'd0 : size_reg - 16'd1;
         seq_phase = PH_IDLE;
         cont_left = 2'd0;
         halt = HALT_NONE;
      endfunction

      function void set_size(logic [15:0] v);
         size_reg = v;
         room = (v == 16'd0) ? 16'd0 : v - 16'd1;
      endfunction

      function void expect_char(logic [7:0] ch, logic e, halt_type st, logic l);
         out_char_type r;
         r.ch = ch;
         r.is_end = e;
         r.status = st;
         r.last = l;
         expected_chars.push_back(r);
      endfunction

      function void drop_string();
         halt = HALT_ENC;
         seq_phase = PH_IDLE;
         cont_left = 2'd0;
      endfunction

      function void predict_chars(logic [7:0] b);
         halt_type st;
         logic ok;
         logic [7:0] c1, c2;
         c1 = 8'h00;
         c2 = 8'h00;
         if (b == END_BYTE) begin
            st = halt;
            if (st == HALT_NONE && seq_phase != PH_IDLE) st = HALT_ENC;
            expect_char(8'h00, 1'b1, st, 1'b1);
            restart();
            return;
         end
         if (halt != HALT_NONE) return;
         if (seq_phase == PH_IDLE) begin
            if (room == 16'd0) begin
               halt = HALT_TRUNC;
               return;
            end
            if (b < ASCII_LIMIT) begin
               expect_char((b >= UPPER_A && b <= UPPER_Z) ? b + CASE_OFFSET : b,
                           1'b0, HALT_NONE, 1'b1);
               room = room - 16'd1;
               return;
            end
            if (b >= LEAD_C2 && b <= LEAD_DF) begin
               seq_phase = (b == LEAD_C3) ? PH_C3 : PH_GEN;
               cont_left = 2'd1;
            end else if (b >= LEAD_E0 && b <= LEAD_EF) begin
               seq_phase = (b == LEAD_E0) ? PH_HIGH : (b == LEAD_E1) ? PH_E1 :
                           (b == LEAD_ED) ? PH_LOW : PH_GEN;
               cont_left = 2'd2;
            end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
               seq_phase = (b == LEAD_F0) ? PH_HIGH : (b == LEAD_F4) ? PH_LOW : PH_GEN;
               cont_left = 2'd3;
            end else begin
               drop_string();
            end
            return;
         end
         if (seq_phase == PH_HIGH)
            ok = (cont_left == 2'd2) ? (b >= E0_SECOND_MIN && b <= CONT_MAX)
                                     : (b >= F0_SECOND_MIN && b <= CONT_MAX);
         else if (seq_phase == PH_LOW)
            ok = (cont_left == 2'd2) ? (b >= CONT_MIN && b <= ED_SECOND_MAX)
                                     : (b >= CONT_MIN && b <= F4_SECOND_MAX);
         else
            ok = (b[7:6] == 2'b10);
         if (!ok || cont_left == 2'd0) begin
            drop_string();
            return;
         end
         cont_left = cont_left - 2'd1;
         if (seq_phase == PH_C3) begin
            case (b)
               TAIL_AE_LO, TAIL_AE_UP: begin
                  c1 = CHAR_A;
                  c2 = CHAR_E;
               end
               TAIL_OE_LO, TAIL_OE_UP: begin
                  c1 = CHAR_O;
                  c2 = CHAR_E;
               end
               TAIL_UE_LO, TAIL_UE_UP: begin
                  c1 = CHAR_U;
                  c2 = CHAR_E;
               end
               CONT_9F: begin
                  c1 = CHAR_S;
                  c2 = CHAR_S;
               end
               default: ;
            endcase
         end else if (seq_phase == PH_E1BA && b == CONT_9E) begin
            c1 = CHAR_S;
            c2 = CHAR_S;
         end
         if (cont_left != 2'd0) begin
            seq_phase = (seq_phase == PH_E1 && b == CONT_BA) ? PH_E1BA : PH_GEN;
            return;
         end
         seq_phase = PH_IDLE;
         if (c1 != 8'h00 && room >= 16'd2) begin
            expect_char(c1, 1'b0, HALT_NONE, 1'b0);
            expect_char(c2, 1'b0, HALT_NONE, 1'b1);
            room = room - 16'd2;
         end else begin
            expect_char(CHAR_QMARK, 1'b0, HALT_NONE, 1'b1);
            if (room > 16'd0) room = room - 16'd1;
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_char(logic [7:0] ch, logic e, logic [1:0] st, logic l);
         out_char_type w;
         chars_checked++;
         if (expected_chars.size() == 0) begin
            $error("unexpected result: out_char %0h is_end %0b status %0d", ch, e, st);
            errors++;
            return;
         end
         w = expected_chars.pop_front();
         compare_field("out_char", w.ch, ch);
         compare_field("is_end", 8'(w.is_end), 8'(e));
         compare_field("status", 8'(w.status), 8'(st));
         compare_field("last", 8'(w.last), 8'(l));
         if (w.is_end) ends_by_status[w.status]++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_is_end;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_out_size = SIZE_RESET;

   char_stream_scoreboard sb = new();
   logic [7:0] string_bytes[$];
   logic no_gaps = 1'b0;
   logic hold_rsp_req = 1'b0;
   int bytes_sent = 0;
   int size_writes = 0;

   utf8_umlaut_transliterator uut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_is_end   (rsp_is_end),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_out_size (csr_out_size)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic push_byte(input logic [7:0] b);
      if (!no_gaps) begin
         while ($urandom_range(99) < 25) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      end
      req_push <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      sb.predict_chars(b);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [15:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_out_size <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_size(v);
      size_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic send_string_bytes();
      while (string_bytes.size() != 0) push_byte(string_bytes.pop_front());
   endtask

   function automatic logic [7:0] any_cont();
      return 8'($urandom_range(CONT_MIN, CONT_MAX));
   endfunction

   function automatic void add_random_char();
      int kind;
      logic [7:0] lead;
      logic [7:0] second;
      kind = $urandom_range(99);
      if (kind < 35) begin
         string_bytes.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 55) begin
         string_bytes.push_back(LEAD_C3);
         string_bytes.push_back(UMLAUT_TAILS[$urandom_range(6)]);
      end else if (kind < 60) begin
         string_bytes.push_back(LEAD_E1);
         string_bytes.push_back(CONT_BA);
         string_bytes.push_back(CONT_9E);
      end else if (kind < 70) begin
         string_bytes.push_back(8'($urandom_range(LEAD_C2, LEAD_DF)));
         string_bytes.push_back(any_cont());
      end else if (kind < 80) begin
         lead = 8'($urandom_range(LEAD_E0, LEAD_EF));
         if (lead == LEAD_E0) second = 8'($urandom_range(E0_SECOND_MIN, CONT_MAX));
         else if (lead == LEAD_ED) second = 8'($urandom_range(CONT_MIN, ED_SECOND_MAX));
         else if (lead == LEAD_E1 && $urandom_range(1) == 1) second = CONT_BA;
         else second = any_cont();
         string_bytes.push_back(lead);
         string_bytes.push_back(second);
         if (second == CONT_BA && $urandom_range(1) == 1) string_bytes.push_back(CONT_9E);
         else string_bytes.push_back(any_cont());
      end else if (kind < 88) begin
         lead = 8'($urandom_range(LEAD_F0, LEAD_F4));
         if (lead == LEAD_F0) second = 8'($urandom_range(F0_SECOND_MIN, CONT_MAX));
         else if (lead == LEAD_F4) second = 8'($urandom_range(CONT_MIN, F4_SECOND_MAX));
         else second = any_cont();
         string_bytes.push_back(lead);
         string_bytes.push_back(second);
         string_bytes.push_back(any_cont());
         string_bytes.push_back(any_cont());
      end else if (kind < 96) begin
         string_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
         string_bytes.push_back(8'($urandom_range(LEAD_C2, LEAD_F4)));
      end
   endfunction

   initial begin
      int hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_char(rsp_out_char, rsp_is_end, rsp_status, rsp_last);
         if (hold_rsp_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (no_gaps) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= 25);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_utf8_umlaut_transliterator: errors");
      $finish;
   end

   initial begin
      int phase_start;
      int n_chars;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ASCII extremes, each umlaut family, sharp s, generic 4-byte, stray continuation,
      // terminator inside a sequence
      string_bytes = '{UPPER_A, UPPER_Z, 8'h7F, 8'h01,
                       LEAD_C3, TAIL_AE_UP, LEAD_C3, TAIL_OE_LO, LEAD_C3, TAIL_UE_UP,
                       LEAD_E1, CONT_BA, CONT_9E,
                       LEAD_F4, F4_SECOND_MAX, CONT_MAX, CONT_MAX, END_BYTE,
                       CONT_MIN, UPPER_A, END_BYTE,
                       LEAD_C3, END_BYTE};
      send_string_bytes();

      for (int i = 0; i < 8; i++) begin
         write_size(SIZE_PLAN[i]);
         no_gaps = (i == 6);
         if (i == 3) hold_rsp_req = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            n_chars = $urandom_range(0, 10);
            repeat (n_chars) add_random_char();
            string_bytes.push_back(END_BYTE);
            send_string_bytes();
         end
         // leave a string open across the next size write
         if (i == 1 || i == 5) begin
            repeat (3) string_bytes.push_back(8'($urandom_range(UPPER_A, UPPER_Z)));
            send_string_bytes();
         end
      end
      no_gaps = 1'b0;

      wait_drained();
      $display("bytes pushed %0d, results checked %0d, size writes %0d",
               bytes_sent, sb.chars_checked, size_writes);
      $display("strings ended ok %0d, truncated %0d, encoding error %0d",
               sb.ends_by_status[HALT_NONE], sb.ends_by_status[HALT_TRUNC],
               sb.ends_by_status[HALT_ENC]);
      if (sb.errors == 0)
         $display("tb_utf8_umlaut_transliterator: clean");
      else
         $display("tb_utf8_umlaut_transliterator: errors");
      $finish;
   end

endmodule

// ===== utf8_umlaut_transliterator.f =====
hw/rtl/u8ut_pkg.sv
hw/rtl/u8ut_front.sv
hw/rtl/u8ut_fifo.sv
hw/rtl/u8ut_back.sv
hw/rtl/utf8_umlaut_transliterator.sv
bench/tb_utf8_umlaut_transliterator.sv
